// ----- rtl/lbbr_pkg.sv -----
// ----------------------------------------------------------------------------
// lbbr_pkg: shared types and constants for the balanced bracket run block
// Holds the stack cell command codes and the fixed character and output
// constants.
// ----------------------------------------------------------------------------
package lbbr_pkg;

	// Command for the cells of the position stack; a load reaches only the first cell
	typedef enum logic [1:0] {
		STK_HOLD = 2'd0,
		STK_PUSH = 2'd1,
		STK_POP  = 2'd2,
		STK_LOAD = 2'd3
	} stk_op_t;

	// Character that opens a bracket; every other byte closes
	localparam logic [7:0] OPEN_SYMBOL = 8'h28;

	// Width and saturation limit of the reported length
	localparam int unsigned OUT_W = 10;
	localparam logic [OUT_W-1:0] LEN_LIMIT = 10'd1023;

endpackage

// ----- rtl/lbbr_cell.sv -----
// ----------------------------------------------------------------------------
// lbbr_cell: one entry of the shifting position stack
// Takes the value of the neighbor above on a push, of the neighbor below on
// a pop, and the load value on a load; holds otherwise.
// ----------------------------------------------------------------------------
module lbbr_cell #(
	parameter int unsigned WIDTH = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lbbr_pkg::stk_op_t  op,
	input  logic [WIDTH-1:0]   up_in,
	input  logic [WIDTH-1:0]   down_in,
	output logic [WIDTH-1:0]   value
);

	logic [WIDTH-1:0] value_q;

	// Shift, load or hold the stored position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else begin
			case (op)
				lbbr_pkg::STK_PUSH: value_q <= up_in;
				lbbr_pkg::STK_POP:  value_q <= down_in;
				lbbr_pkg::STK_LOAD: value_q <= up_in;
				default:            value_q <= value_q;
			endcase
		end
	end

	assign value = value_q;

endmodule

// ----- rtl/lbbr_stack.sv -----
// ----------------------------------------------------------------------------
// lbbr_stack: position stack built as a chain of shifting cells
// The top of stack sits in the first cell; pushes shift the chain down and
// pops shift it up. Only the first cell takes a load.
// ----------------------------------------------------------------------------
module lbbr_stack #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lbbr_pkg::stk_op_t  op,
	input  logic [WIDTH-1:0]   push_val,
	output logic [WIDTH-1:0]   top1
);

	logic [WIDTH-1:0] cell_val [DEPTH];

	// Build the chain; a load reaches the first cell only
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lbbr_pkg::stk_op_t cell_op;
		logic [WIDTH-1:0]  up_val;
		logic [WIDTH-1:0]  down_val;

		if (i == 0) begin : g_first
			assign up_val  = push_val;
			assign cell_op = op;
		end else begin : g_rest
			assign up_val  = cell_val[i-1];
			assign cell_op = (op == lbbr_pkg::STK_LOAD) ? lbbr_pkg::STK_HOLD : op;
		end

		if (i == DEPTH - 1) begin : g_last
			assign down_val = '0;
		end else begin : g_inner
			assign down_val = cell_val[i+1];
		end

		lbbr_cell #(
			.WIDTH (WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (cell_op),
			.up_in   (up_val),
			.down_in (down_val),
			.value   (cell_val[i])
		);
	end

	assign top1 = cell_val[1];

endmodule

// ----- rtl/longest_balanced_bracket_run_top.sv -----
// ----------------------------------------------------------------------------
// longest_balanced_bracket_run_top: longest well-formed bracket run finder
// Streams characters, tracks open positions on a shifting stack and reports
// the longest balanced substring on the last character of each string.
// ----------------------------------------------------------------------------
// The block takes one character transaction per clock, with no gaps, as long
// as the output side keeps up; while a result waits unread in the output
// register, the input stalls. Each character is a single push, pop, reload
// or hold of the position stack, a chain of MAX_LEN+1 cells whose second
// cell feeds one subtract and compare. A result is registered and appears
// in the cycle after the character that ends its string is taken. Characters
// past MAX_LEN in a string are dropped and flag overflow; lengths above 1023
// saturate.
module longest_balanced_bracket_run_top #(
	parameter int unsigned MAX_LEN = 1023
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 symbol,
	input  logic                       end_of_string,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lbbr_pkg::OUT_W-1:0] longest_length,
	output logic                       overflow
);

	localparam int unsigned DEPTH = MAX_LEN + 1;
	localparam int unsigned PW    = $clog2(MAX_LEN + 1);
	localparam int unsigned SW    = $clog2(MAX_LEN + 2);
	localparam int unsigned BW    = (PW > lbbr_pkg::OUT_W) ? PW : lbbr_pkg::OUT_W;

	logic [PW-1:0]     count_q;
	logic [SW-1:0]     sp_q;
	logic [PW-1:0]     best_q;
	logic              overflowed_q;
	logic              out_valid_q;
	logic [lbbr_pkg::OUT_W-1:0] longest_q;
	logic              overflow_q;

	logic              accept;
	logic              ignore_char;
	logic              is_open;
	logic [PW-1:0]     pos;
	logic [PW-1:0]     top1;
	logic [PW-1:0]     run;
	logic [PW-1:0]     best_next;
	logic [BW-1:0]     best_ext;
	logic [lbbr_pkg::OUT_W-1:0] best_sat;
	lbbr_pkg::stk_op_t stk_op;
	logic [PW-1:0]     stk_val;
	logic [SW-1:0]     sp_next;

	// Accept while the output register is free or draining
	assign in_ready    = !out_valid_q || out_ready;
	assign accept      = in_valid && in_ready;
	assign ignore_char = (count_q >= PW'(MAX_LEN));
	assign is_open     = (symbol == lbbr_pkg::OPEN_SYMBOL);
	assign pos         = count_q + PW'(1);

	// Measure the run that closes against the entry under the top
	assign run = (pos >= top1) ? (pos - top1) : '0;

	always_comb begin
		best_next = best_q;
		if (!ignore_char && !is_open && (sp_q >= SW'(2)) && (run > best_q)) begin
			best_next = run;
		end
	end

	// Saturate the final length to the output width
	assign best_ext = BW'(best_next);
	assign best_sat = (best_ext > BW'(lbbr_pkg::LEN_LIMIT)) ? lbbr_pkg::LEN_LIMIT
	                                                        : best_ext[lbbr_pkg::OUT_W-1:0];

	// Pick the stack command and the next stack pointer
	always_comb begin
		stk_op  = lbbr_pkg::STK_HOLD;
		stk_val = pos;
		sp_next = sp_q;
		if (accept) begin
			if (end_of_string) begin
				stk_op  = lbbr_pkg::STK_LOAD;
				stk_val = '0;
				sp_next = SW'(1);
			end else if (ignore_char) begin
				stk_op  = lbbr_pkg::STK_HOLD;
			end else if (is_open) begin
				stk_op  = lbbr_pkg::STK_PUSH;
				sp_next = sp_q + SW'(1);
			end else if (sp_q <= SW'(1)) begin
				stk_op  = lbbr_pkg::STK_LOAD;
				sp_next = SW'(1);
			end else begin
				stk_op  = lbbr_pkg::STK_POP;
				sp_next = sp_q - SW'(1);
			end
		end
	end

	lbbr_stack #(
		.DEPTH (DEPTH),
		.WIDTH (PW)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (stk_op),
		.push_val (stk_val),
		.top1     (top1)
	);

	// Advance the per-string state; clear it after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			sp_q         <= SW'(1);
			best_q       <= '0;
			overflowed_q <= 1'b0;
		end else if (accept) begin
			sp_q <= sp_next;
			if (end_of_string) begin
				count_q      <= '0;
				best_q       <= '0;
				overflowed_q <= 1'b0;
			end else if (ignore_char) begin
				overflowed_q <= 1'b1;
			end else begin
				count_q <= pos;
				best_q  <= best_next;
			end
		end
	end

	// Hold the result until the output transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && end_of_string) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && end_of_string) begin
			longest_q  <= best_sat;
			overflow_q <= overflowed_q || ignore_char;
		end
	end

	assign out_valid      = out_valid_q;
	assign longest_length = longest_q;
	assign overflow       = overflow_q;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the longest balanced bracket run finder
// Streams strings of bracket characters through the block: a short table of
// hand-picked strings first, then random strings. The random strings are
// mostly well formed with random nesting, with some noisy ones and one long
// string that runs past MAX_LEN. A bench-side tracker of the position stack
// predicts every result. Both sides stall at random. The receiver holds off
// once for a long stretch, and the sender pauses until all results have come.
// ----------------------------------------------------------------------------
module tb;

	localparam int MAX_LEN       = 1023;
	localparam int POS_W         = $clog2(MAX_LEN + 1);
	localparam logic [7:0] CLOSE_SYMBOL = 8'h29;
	localparam int RANDOM_ITEMS  = 900;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_SHOWN     = 10;

	typedef struct packed {
		logic [lbbr_pkg::OUT_W-1:0] len;
		logic                       ovf;
	} run_result_t;

	typedef struct packed {
		logic [7:0]  sym;
		logic        eos;
		logic        typed;
		run_result_t res;
	} stim_row_t;

	typedef logic [7:0] text_t [$];

	// Hand-picked strings; typed rows carry their result, the rest use the tracker
	localparam stim_row_t DIRECTED [23] = '{
		// lone open bracket
		{lbbr_pkg::OPEN_SYMBOL, 1'b1, 1'b1, 10'd0, 1'b0},
		// lone close bracket
		{CLOSE_SYMBOL, 1'b1, 1'b1, 10'd0, 1'b0},
		// one pair
		{lbbr_pkg::OPEN_SYMBOL, 1'b0, 1'b0, 10'd0, 1'b0},
		{CLOSE_SYMBOL, 1'b1, 1'b1, 10'd2, 1'b0},
		// byte extremes, both act as close
		{8'h00,        1'b0, 1'b0, 10'd0, 1'b0},
		{8'hFF,        1'b1, 1'b1, 10'd0, 1'b0},
		// nested pair closed by other bytes
		{lbbr_pkg::OPEN_SYMBOL, 1'b0, 1'b0, 10'd0, 1'b0},
		{lbbr_pkg::OPEN_SYMBOL, 1'b0, 1'b0, 10'd0, 1'b0},
		{8'hFF,        1'b0, 1'b0, 10'd0, 1'b0},
		{8'h00,        1'b1, 1'b0, 10'd0, 1'b0},
		// leading and trailing stray closes around a run
		{CLOSE_SYMBOL, 1'b0, 1'b0, 10'd0, 1'b0},
		{lbbr_pkg::OPEN_SYMBOL, 1'b0, 1'b0, 10'd0, 1'b0},
		{CLOSE_SYMBOL, 1'b0, 1'b0, 10'd0, 1'b0},
		{lbbr_pkg::OPEN_SYMBOL, 1'b0, 1'b0, 10'd0, 1'b0},
		{CLOSE_SYMBOL, 1'b0, 1'b0, 10'd0, 1'b0},
		{CLOSE_SYMBOL, 1'b1, 1'b0, 10'd0, 1'b0},
		// unmatched open in the middle
		{lbbr_pkg::OPEN_SYMBOL, 1'b0, 1'b0, 10'd0, 1'b0},
		{CLOSE_SYMBOL, 1'b0, 1'b0, 10'd0, 1'b0},
		{lbbr_pkg::OPEN_SYMBOL, 1'b0, 1'b0, 10'd0, 1'b0},
		{lbbr_pkg::OPEN_SYMBOL, 1'b0, 1'b0, 10'd0, 1'b0},
		{CLOSE_SYMBOL, 1'b1, 1'b0, 10'd0, 1'b0},
		// bytes just below the open code or with its top bit set still close
		{8'h27,        1'b0, 1'b0, 10'd0, 1'b0},
		{8'hA8,        1'b1, 1'b1, 10'd0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] symbol = 8'h00;
	logic end_of_string = 1'b0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	logic [lbbr_pkg::OUT_W-1:0] longest_length;
	logic overflow;

	// Bench copy of the position stack and run tracking
	logic [POS_W-1:0] open_pos [MAX_LEN + 1];
	logic [POS_W:0]   stack_depth;
	logic [POS_W:0]   chars_seen;
	logic [POS_W-1:0] best_run;
	logic             seen_overflow;

	run_result_t result_q [$];
	int fail_count = 0;
	bit burst = 1'b0;
	bit hold_req = 1'b0;

	longest_balanced_bracket_run_top #(
		.MAX_LEN(MAX_LEN)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.symbol        (symbol),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.longest_length(longest_length),
		.overflow      (overflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_tracker();
		open_pos[0] = '0;
		stack_depth = (POS_W + 1)'(1);
		chars_seen = '0;
		best_run = '0;
		seen_overflow = 1'b0;
	endfunction

	// Advance the tracker by one character; return 1 when a string ends
	function automatic bit track_symbol(input logic [7:0] s, input logic last,
			output run_result_t res);
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] run;
		logic [POS_W-1:0] top;
		res = '0;
		if (chars_seen >= MAX_LEN) begin
			seen_overflow = 1'b1;
		end else begin
			chars_seen = chars_seen + 1'b1;
			pos = chars_seen[POS_W-1:0];
			if (s == lbbr_pkg::OPEN_SYMBOL) begin
				if (stack_depth <= MAX_LEN) begin
					open_pos[stack_depth[POS_W-1:0]] = pos;
					stack_depth = stack_depth + 1'b1;
				end
			end else begin
				if (stack_depth > 0)
					stack_depth = stack_depth - 1'b1;
				// empty stack: this close becomes the new base
				if (stack_depth == 0) begin
					open_pos[0] = pos;
					stack_depth = (POS_W + 1)'(1);
				end else begin
					top = open_pos[stack_depth[POS_W-1:0] - 1'b1];
					run = (pos >= top) ? pos - top : '0;
					if (run > best_run)
						best_run = run;
				end
			end
		end
		if (!last)
			return 1'b0;
		res.len = (best_run > lbbr_pkg::LEN_LIMIT) ? lbbr_pkg::LEN_LIMIT
		                                           : best_run[lbbr_pkg::OUT_W-1:0];
		res.ovf = seen_overflow;
		clear_tracker();
		return 1'b1;
	endfunction

	// Build a string: nested (opens, then closes) when opens > 0, else a
	// random walk kept near balance, with noise_pct percent random bytes
	function automatic text_t compose_text(input int len, input int noise_pct,
			input int opens);
		text_t text;
		int depth;
		logic [7:0] c;
		depth = 0;
		for (int i = 0; i < len; i++) begin
			if (opens > 0) begin
				c = (i < opens) ? lbbr_pkg::OPEN_SYMBOL : CLOSE_SYMBOL;
			end else if ($urandom_range(0, 99) < noise_pct) begin
				c = 8'($urandom_range(0, 255));
			end else if (depth == 0 || (depth < len - i - 1 && $urandom_range(0, 1) == 1)) begin
				c = lbbr_pkg::OPEN_SYMBOL;
			end else if ($urandom_range(0, 3) == 0) begin
				c = 8'($urandom_range(0, 255));
				if (c == lbbr_pkg::OPEN_SYMBOL)
					c = CLOSE_SYMBOL;
			end else begin
				c = CLOSE_SYMBOL;
			end
			if (c == lbbr_pkg::OPEN_SYMBOL)
				depth++;
			else if (depth > 0)
				depth--;
			text = {text, c};
		end
		return text;
	endfunction

	// Offer one character transaction and log its expected result
	task automatic send_char(input logic [7:0] s, input logic last, input logic typed,
			input run_result_t typed_res);
		int gap;
		run_result_t predicted;
		gap = burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		symbol <= s;
		end_of_string <= last;
		do @(posedge clk); while (!in_ready);
		if (track_symbol(s, last, predicted))
			result_q = {result_q, (typed ? typed_res : predicted)};
	endtask

	task automatic send_string(input text_t text);
		foreach (text[i])
			send_char(text[i], i == text.size() - 1, 1'b0, '0);
	endtask

	// Drop valid and hold until every expected result is in
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (result_q.size() != 0);
	endtask

	// Stimulus
	initial begin
		text_t text;
		int long_len [$];
		int long_opens [$];
		int strings;
		int short_items;
		int hold_at;
		int pause_at;
		int len;
		int pick;
		int noise;
		clear_tracker();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			send_char(DIRECTED[i].sym, DIRECTED[i].eos, DIRECTED[i].typed, DIRECTED[i].res);
		wait_drained();

		// Long string: deep nest that closes into a long run, then runs past the limit
		long_len = '{MAX_LEN + 4};
		long_opens = '{(MAX_LEN - 1) / 2};
		hold_at = $urandom_range(5, 30);
		pause_at = $urandom_range(40, 70);
		strings = 0;
		short_items = 0;
		while (short_items < RANDOM_ITEMS || long_len.size() != 0) begin
			strings++;
			// Fill the block while the receiver holds off
			if (strings == hold_at) begin
				hold_req = 1'b1;
				burst = 1'b1;
				repeat (40)
					send_string(compose_text($urandom_range(1, 3), 0, 0));
			end
			if (strings == pause_at)
				wait_drained();
			if (long_len.size() != 0 &&
					(short_items >= RANDOM_ITEMS || $urandom_range(0, 39) == 0)) begin
				text = compose_text(long_len.pop_front(), 0, long_opens.pop_front());
			end else begin
				pick = $urandom_range(0, 9);
				noise = (pick < 7) ? $urandom_range(0, 5) : (pick < 9) ? 50 : 100;
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 24);
				text = compose_text(len, noise, 0);
				short_items += len;
			end
			burst = ($urandom_range(0, 7) == 0);
			send_string(text);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && result_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Result side: random ready gaps, one long hold-off on request
	initial begin
		int gap;
		run_result_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = burst ? 0 : $urandom_range(0, 17);
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			// Compare the transaction against the oldest expectation
			if (result_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_SHOWN)
					$display("unexpected result: len %0d ovf %0b", longest_length, overflow);
			end else begin
				want = result_q.pop_front();
				if (longest_length !== want.len || overflow !== want.ovf) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN)
						$display("result mismatch: expected len %0d ovf %0b, got len %0d ovf %0b",
							want.len, want.ovf, longest_length, overflow);
				end
			end
		end
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
